@@ hdl/mmp_pkg.sv @@
// Package with shared constants and types.
package mmp_pkg;
	localparam int unsigned MaxSize = 4;
	localparam int unsigned ElemW = 31;
	localparam int unsigned ExpW = 63;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 31;
	localparam logic [CfgIdxW-1:0] RegModulus = 1'd0;
	localparam logic [CfgIdxW-1:0] RegSize = 1'd1;
	localparam logic [ElemW-1:0] ModulusReset = 31'd1000000007;
	localparam logic [2:0] SizeReset = 3'd3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_MUL,
		ST_NEXT,
		ST_EMIT
	} state_t;

	// Control handed from the sequencer to every cell of the chain.
	typedef struct packed {
		logic start;
		logic step;
		logic clear;
	} cell_ctrl_t;
endpackage

@@ hdl/mmp_if.sv @@
// Valid/ready channel interfaces for input items, results and configuration.
interface mmp_in_if;
	logic valid;
	logic ready;
	logic [mmp_pkg::ElemW-1:0] element;
	logic [mmp_pkg::ExpW-1:0] exponent;
	logic last_element;
	modport source(output valid, element, exponent, last_element, input ready);
	modport sink(input valid, element, exponent, last_element, output ready);
endinterface

interface mmp_out_if;
	logic valid;
	logic ready;
	logic [mmp_pkg::ElemW-1:0] value;
	logic last_value;
	modport source(output valid, value, last_value, input ready);
	modport sink(input valid, value, last_value, output ready);
endinterface

interface mmp_cfg_if;
	logic valid;
	logic ready;
	logic [mmp_pkg::CfgIdxW-1:0] index;
	logic [mmp_pkg::CfgDataW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/mmp_cell.sv @@
// One multiply-accumulate cell: folds one term a*b mod m into its running sum.
module mmp_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mmp_pkg::cell_ctrl_t        ctrl,
	input  logic [mmp_pkg::ElemW-1:0]  a,
	input  logic [mmp_pkg::ElemW-1:0]  b,
	input  logic [mmp_pkg::ElemW-1:0]  modulus,
	output logic                       busy,
	output logic [mmp_pkg::ElemW-1:0]  acc
);
	// The product is reduced by a bit-serial shift-subtract over 62 steps.
	localparam int unsigned PW = 2 * mmp_pkg::ElemW;
	localparam int unsigned CW = $clog2(PW + 1);

	typedef logic [mmp_pkg::ElemW-1:0] ElemW_t;

	logic [PW-1:0] prod_q;
	logic [mmp_pkg::ElemW:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [mmp_pkg::ElemW-1:0] acc_q;
	logic [mmp_pkg::ElemW-1:0] acc_nx;
	logic [mmp_pkg::ElemW+1:0] rem_sh;
	logic [mmp_pkg::ElemW+1:0] rem_nx;
	logic [mmp_pkg::ElemW+1:0] sum;

	assign rem_sh = {rem_q, prod_q[PW-1]};
	assign rem_nx = (rem_sh >= {2'b00, modulus}) ? rem_sh - {2'b00, modulus} : rem_sh;
	assign sum = {2'b00, acc_q} + {1'b0, rem_q};
	// The output already holds the current term, so a row can be written back
	// at the edge that takes its last term.
	assign acc_nx = (sum >= {2'b00, modulus}) ? ElemW_t'(sum - {2'b00, modulus})
		: ElemW_t'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= CW'(PW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.step) begin
			acc_q <= acc_nx;
		end
		if (ctrl.start) begin
			prod_q <= PW'(a) * PW'(b);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			prod_q <= {prod_q[PW-2:0], 1'b0};
			rem_q <= rem_nx[mmp_pkg::ElemW:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign acc = acc_nx;
endmodule

@@ hdl/modular_matrix_power_unit.sv @@
// Top level: element load, square-and-multiply sequencer and the cell chain.
// Usage: configure modulus (index 0) and matrix_size (index 1) while idle.
// Send size*size elements row-major on the input channel; the transfer with
// last_element set also carries the exponent and starts the job. Extra
// elements beyond size*size are ignored. Results leave row-major on the
// output channel, last_value set on the final one.
// Each matrix product runs size entries at once through a chain of MAX_SIZE
// cells, one cell per column; each term passes through a cell's bit-serial
// reducer before the next term is launched, and a job runs one product per
// exponent bit plus one per set bit. One job is in flight at a time; input
// is not taken while computing or emitting. A stalled receiver holds the
// current result and the block waits. Reset clears the control registers
// and the load index and sets modulus and size to their defaults; matrix
// stores hold no reset value. A modulus of zero acts as one.
module modular_matrix_power_unit #(
	parameter int unsigned MAX_SIZE = mmp_pkg::MaxSize
) (
	input logic clk,
	input logic arst_n,
	mmp_in_if.sink   in_ch,
	mmp_out_if.source out_ch,
	mmp_cfg_if.sink  cfg
);
	localparam int unsigned IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int unsigned N = MAX_SIZE * MAX_SIZE;
	localparam int unsigned NW = $clog2(N + 1);
	localparam int unsigned SW = $clog2(MAX_SIZE + 1);
	localparam int unsigned EW = mmp_pkg::ElemW;

	typedef logic [EW-1:0] el_t;

	logic [EW-1:0] modulus_q;
	logic [2:0] size_q;
	el_t base_q [MAX_SIZE][MAX_SIZE];
	el_t res_q [MAX_SIZE][MAX_SIZE];
	el_t scr_q [MAX_SIZE][MAX_SIZE];
	el_t tmp_q [MAX_SIZE][MAX_SIZE];
	logic [NW-1:0] load_q;
	logic [mmp_pkg::ExpW-1:0] exp_q;
	mmp_pkg::state_t state_q, state_d;
	logic sq_q;           // 0: result*square pass, 1: square*square pass
	logic [IW-1:0] row_q, k_q, oi_q, oj_q;
	logic phase_q;        // 0: launch terms, 1: wait for reducers
	mmp_pkg::cell_ctrl_t ctrl;
	logic [MAX_SIZE-1:0] busy;
	el_t acc [MAX_SIZE];
	el_t a_op;
	logic [SW-1:0] s;
	el_t m;
	logic [IW-1:0] ld_row, ld_col;
	logic in_fire, last_k, last_row, last_oj, last_oi;

	always_comb begin
		if (size_q == 3'd0) s = SW'(1);
		else if (32'(size_q) > MAX_SIZE) s = SW'(MAX_SIZE);
		else s = SW'(size_q);
	end
	assign m = (modulus_q == '0) ? el_t'(1) : modulus_q;
	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == mmp_pkg::ST_LOAD);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign last_k = (32'(k_q) == 32'(s) - 1);
	assign last_row = (32'(row_q) == 32'(s) - 1);
	assign last_oj = (32'(oj_q) == 32'(s) - 1);
	assign last_oi = (32'(oi_q) == 32'(s) - 1);

	// Row and column of the load index, found by comparing against row starts.
	always_comb begin
		ld_row = '0;
		for (int r = 1; r < MAX_SIZE; r++)
			if (32'(load_q) >= 32'(r) * 32'(s)) ld_row = IW'(r);
		ld_col = IW'(32'(load_q) - 32'(ld_row) * 32'(s));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mmp_pkg::ModulusReset;
			size_q <= mmp_pkg::SizeReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				mmp_pkg::RegModulus: modulus_q <= cfg.data;
				mmp_pkg::RegSize: size_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// Cell j forms entry (row, j): a operand from the row, b from square column j.
	assign a_op = sq_q ? scr_q[row_q][k_q] : res_q[row_q][k_q];
	for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
		mmp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
			.a(a_op), .b(scr_q[k_q][j]), .modulus(m),
			.busy(busy[j]), .acc(acc[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmp_pkg::ST_LOAD;
			load_q <= '0;
			exp_q <= '0;
			sq_q <= 1'b0;
			row_q <= '0;
			k_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				mmp_pkg::ST_LOAD: if (in_fire) begin
					if (32'(load_q) < 32'(s) * 32'(s)) load_q <= load_q + 1'b1;
					if (in_ch.last_element) begin
						exp_q <= in_ch.exponent;
						sq_q <= ~in_ch.exponent[0];
						row_q <= '0;
						k_q <= '0;
						phase_q <= 1'b0;
					end
				end
				mmp_pkg::ST_MUL: begin
					if (!phase_q) phase_q <= 1'b1;
					else if (busy == '0) begin
						phase_q <= 1'b0;
						if (last_k) begin
							k_q <= '0;
							if (last_row) row_q <= '0;
							else row_q <= row_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				mmp_pkg::ST_NEXT: begin
					if (!sq_q) sq_q <= 1'b1;
					else begin
						exp_q <= exp_q >> 1;
						sq_q <= ~exp_q[1];
					end
				end
				mmp_pkg::ST_EMIT: if (out_ch.ready) begin
					if (last_oj) begin
						oj_q <= '0;
						if (last_oi) begin
							oi_q <= '0;
							load_q <= '0;
						end else oi_q <= oi_q + 1'b1;
					end else oj_q <= oj_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Matrix stores: element load, identity init, row write-back and square update.
	// The loaded matrix is kept; the running square lives in scr_q.
	always_ff @(posedge clk) begin
		if (in_fire && 32'(load_q) < 32'(s) * 32'(s))
			base_q[ld_row][ld_col] <= in_ch.element;
		if (state_q == mmp_pkg::ST_INIT) begin
			for (int i = 0; i < MAX_SIZE; i++)
				for (int j = 0; j < MAX_SIZE; j++)
					res_q[i][j] <= (i == j && m != el_t'(1)) ? el_t'(1) : '0;
			scr_q <= base_q;
		end
		if (state_q == mmp_pkg::ST_MUL && phase_q && busy == '0 && last_k) begin
			for (int j = 0; j < MAX_SIZE; j++) begin
				if (sq_q) tmp_q[row_q][j] <= acc[j];
				else res_q[row_q][j] <= acc[j];
			end
		end
		if (state_q == mmp_pkg::ST_NEXT && sq_q)
			scr_q <= tmp_q;
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		case (state_q)
			mmp_pkg::ST_LOAD: if (in_fire && in_ch.last_element) state_d = mmp_pkg::ST_INIT;
			mmp_pkg::ST_INIT: begin
				ctrl.clear = 1'b1;
				state_d = (exp_q == '0) ? mmp_pkg::ST_EMIT : mmp_pkg::ST_MUL;
			end
			mmp_pkg::ST_MUL: begin
				if (!phase_q) ctrl.start = 1'b1;
				else if (busy == '0) begin
					// The last term of a row is written back and the sums restart.
					if (last_k) begin
						ctrl.clear = 1'b1;
						if (last_row) state_d = mmp_pkg::ST_NEXT;
					end else begin
						ctrl.step = 1'b1;
					end
				end
			end
			mmp_pkg::ST_NEXT: begin
				ctrl.clear = 1'b1;
				if (sq_q && exp_q[mmp_pkg::ExpW-1:1] == '0) state_d = mmp_pkg::ST_EMIT;
				else state_d = mmp_pkg::ST_MUL;
			end
			mmp_pkg::ST_EMIT:
				if (out_ch.ready && last_oj && last_oi) state_d = mmp_pkg::ST_LOAD;
			default: state_d = mmp_pkg::ST_LOAD;
		endcase
	end

	assign out_ch.valid = (state_q == mmp_pkg::ST_EMIT);
	assign out_ch.value = res_q[oi_q][oj_q];
	assign out_ch.last_value = last_oi && last_oj;
endmodule
